### design/assert_macros.svh
// Assertion macros for the interpolator modules; kli_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define KLI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication, checked outside reset.
`define KLI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/kli_pkg.sv
// Shared types and constants for the keyframe interpolator.
package kli_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int SLOT_W       = 6;
    localparam int TIME_W       = 32;
    localparam int VAL_W        = 32;
    localparam int CNT_W        = 7;
    localparam int FRAC_W       = 16;
    localparam int FACTOR_W     = FRAC_W + 1;
    localparam int AXES         = 3;
    localparam int AXIS_W       = 2;
    localparam int DIV_STEPS    = FRAC_W;
    localparam int PADDR_W      = 2;

    localparam logic       KIND_WRITE = 1'b0;
    localparam logic       KIND_EVAL  = 1'b1;

    localparam logic [PADDR_W-1:0] REG_KEY_COUNT = 2'd0;
    localparam logic [CNT_W-1:0]   KEY_COUNT_RST = 7'd1;

    typedef struct packed {
        logic                     kind;
        logic [SLOT_W-1:0]        key_slot;
        logic [TIME_W-1:0]        sample_time;
        logic signed [VAL_W-1:0]  value_x;
        logic signed [VAL_W-1:0]  value_y;
        logic signed [VAL_W-1:0]  value_z;
    } kli_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  out_x;
        logic signed [VAL_W-1:0]  out_y;
        logic signed [VAL_W-1:0]  out_z;
        logic [SLOT_W-1:0]        segment;
        logic                     out_of_range;
    } kli_out_t;

    // controller -> datapath
    typedef struct packed {
        logic              idle;
        logic              load;
        logic              scan;
        logic              fetch_lo;
        logic              fetch_hi;
        logic              cap_hi;
        logic              classify;
        logic              div_step;
        logic              mul;
        logic              acc;
        logic              publish;
        logic [AXIS_W-1:0] axis;
    } kli_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic eval_req;
        logic single;
        logic scan_hit;
        logic scan_end;
        logic need_div;
        logic out_free;
    } kli_status_t;

endpackage

### design/kli_ctrl.sv
// Sequencer for key search, key fetch, division and per-axis blend.
`include "assert_macros.svh"

module kli_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kli_pkg::kli_status_t status,
    output kli_pkg::kli_cmd_t    cmd
);

    localparam int DCNT_W = $clog2(kli_pkg::DIV_STEPS);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(kli_pkg::DIV_STEPS - 1);
    localparam logic [kli_pkg::AXIS_W-1:0] AXIS_LAST = kli_pkg::AXIS_W'(kli_pkg::AXES - 1);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_SCAN     = 10'b00_0000_0010,
        S_FETCH_LO = 10'b00_0000_0100,
        S_FETCH_HI = 10'b00_0000_1000,
        S_CAP_HI   = 10'b00_0001_0000,
        S_CLASS    = 10'b00_0010_0000,
        S_DIV      = 10'b00_0100_0000,
        S_MUL      = 10'b00_1000_0000,
        S_ACC      = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } state_t;

    state_t                      state_reg, state_next;
    logic [DCNT_W-1:0]           div_cnt_reg, div_cnt_next;
    logic [kli_pkg::AXIS_W-1:0]  axis_reg, axis_next;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        axis_next    = axis_reg;
        cmd          = '0;
        cmd.axis     = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (status.eval_req)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                // hit wins over end when the last key matches
                if (status.single || status.scan_hit || status.scan_end)
                begin
                    state_next = S_FETCH_LO;
                end
            end
            S_FETCH_LO:
            begin
                cmd.fetch_lo = 1'b1;
                state_next   = S_FETCH_HI;
            end
            S_FETCH_HI:
            begin
                cmd.fetch_hi = 1'b1;
                state_next   = S_CAP_HI;
            end
            S_CAP_HI:
            begin
                cmd.cap_hi = 1'b1;
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                cmd.classify = 1'b1;
                div_cnt_next = '0;
                axis_next    = '0;
                state_next   = status.need_div ? S_DIV : S_MUL;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (axis_reg == AXIS_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + kli_pkg::AXIS_W'(1);
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
            axis_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            axis_reg    <= axis_next;
        end
    end

    `KLI_ASSERT_NEXT(a_div_runs_full, clk, rst_n, (state_reg == S_DIV) && (div_cnt_reg != DIV_LAST), state_reg == S_DIV, "division left early")
    `KLI_ASSERT_NEXT(a_result_held, clk, rst_n, (state_reg == S_DONE) && !status.out_free, state_reg == S_DONE, "finished result dropped while output busy")
    `KLI_ASSERT_IMP(a_axis_bound, clk, rst_n, (state_reg == S_MUL) || (state_reg == S_ACC), axis_reg <= AXIS_LAST, "axis counter out of range")

endmodule

### design/kli_datapath.sv
// Key table, search compare, restoring divider, multiplier and result register.
module kli_datapath #(
    parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  kli_pkg::kli_in_t             req_data,
    input  logic [kli_pkg::CNT_W-1:0]    key_count,
    input  kli_pkg::kli_cmd_t            cmd,
    output kli_pkg::kli_status_t         status,
    output logic                         res_valid,
    input  logic                         res_ready,
    output kli_pkg::kli_out_t            res_data
);

    localparam int IDX_W   = $clog2(MAX_KEYS);
    localparam int CW      = ($clog2(MAX_KEYS + 1) > kli_pkg::CNT_W) ?
                             $clog2(MAX_KEYS + 1) : kli_pkg::CNT_W;
    localparam int TW      = kli_pkg::TIME_W;
    localparam int VW      = kli_pkg::VAL_W;
    localparam int FW      = kli_pkg::FACTOR_W;
    localparam int WORD_W  = TW + kli_pkg::AXES * VW;
    localparam int PROD_W  = (VW + 1) + (FW + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_KEYS);
    localparam logic [FW-1:0] FACTOR_ONE = FW'(1) << kli_pkg::FRAC_W;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (kli_pkg::FRAC_W - 1);

    // key table: time in the top bits, then x, y, z
    logic [WORD_W-1:0]   key_mem [MAX_KEYS];
    logic [WORD_W-1:0]   rd_word_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic                wr_en;
    logic [TW-1:0]       rd_time;
    logic signed [VW-1:0] rd_val [kli_pkg::AXES];

    logic [TW-1:0]       t_reg, t0_reg, t1_reg;
    logic [CW-1:0]       n_reg, n_next, kc_ext;
    logic [CW-1:0]       scan_idx_reg, cmp_idx_reg;
    logic                cmp_vld_reg, found_reg;
    logic [IDX_W-1:0]    seg_reg;
    logic signed [VW-1:0] start_reg [kli_pkg::AXES];
    logic signed [VW-1:0] end_reg   [kli_pkg::AXES];
    logic [TW-1:0]       rem_reg, den_reg;
    logic [FW-1:0]       factor_reg;
    logic                flag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VW-1:0] res_reg [kli_pkg::AXES];
    logic                res_valid_reg;
    kli_pkg::kli_out_t   res_data_reg;

    logic                hit, scan_last, t_lt_t0, single, need_div;
    logic [TW:0]         rem_dbl;
    logic                div_ge;
    logic signed [VW-1:0] start_sel, end_sel;
    logic signed [VW:0]  delta_sel;
    logic signed [PROD_W-1:0] biased, shifted;

    assign wr_addr = IDX_W'(req_data.key_slot);
    assign wr_en   = req_valid && cmd.idle && (req_data.kind == kli_pkg::KIND_WRITE)
                     && (CW'(req_data.key_slot) < MAX_CNT);

    always_comb
    begin
        rd_addr = scan_idx_reg[IDX_W-1:0];
        if (cmd.fetch_lo)
        begin
            rd_addr = seg_reg;
        end
        else if (cmd.fetch_hi)
        begin
            rd_addr = seg_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= {req_data.sample_time, req_data.value_x,
                                 req_data.value_y, req_data.value_z};
        end
        rd_word_reg <= key_mem[rd_addr];
    end

    assign rd_time   = rd_word_reg[WORD_W-1 -: TW];
    assign rd_val[0] = rd_word_reg[3*VW-1 -: VW];
    assign rd_val[1] = rd_word_reg[2*VW-1 -: VW];
    assign rd_val[2] = rd_word_reg[VW-1 -: VW];

    // key count: zero acts as one, beyond the table acts as the table size
    assign kc_ext = CW'(key_count);
    assign n_next = (kc_ext == '0) ? CW'(1) : ((kc_ext > MAX_CNT) ? MAX_CNT : kc_ext);

    assign single    = (n_reg == CW'(1));
    assign hit       = cmp_vld_reg && (t_reg < rd_time);
    assign scan_last = cmp_vld_reg && (cmp_idx_reg == n_reg - CW'(1));
    assign t_lt_t0   = (t_reg < t0_reg);
    assign need_div  = !single && found_reg && !t_lt_t0;

    assign rem_dbl = {rem_reg, 1'b0};
    assign div_ge  = (rem_dbl >= {1'b0, den_reg});

    assign start_sel = start_reg[cmd.axis];
    assign end_sel   = end_reg[cmd.axis];
    assign delta_sel = {end_sel[VW-1], end_sel} - {start_sel[VW-1], start_sel};
    assign biased    = prod_reg + ROUND_HALF;
    assign shifted   = biased >>> kli_pkg::FRAC_W;

    // sequencing flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cmp_vld_reg <= 1'b0;
                found_reg   <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cmp_vld_reg <= 1'b1;
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.publish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg        <= req_data.sample_time;
            n_reg        <= n_next;
            scan_idx_reg <= CW'(1);
            seg_reg      <= '0;
        end
        if (cmd.scan)
        begin
            scan_idx_reg <= scan_idx_reg + CW'(1);
            cmp_idx_reg  <= scan_idx_reg;
            if (hit)
            begin
                seg_reg <= IDX_W'(cmp_idx_reg - CW'(1));
            end
            else if (scan_last)
            begin
                seg_reg <= IDX_W'(n_reg - CW'(2));
            end
        end
        if (cmd.fetch_hi)
        begin
            t0_reg <= rd_time;
            for (int a = 0; a < kli_pkg::AXES; a++)
            begin
                start_reg[a] <= rd_val[a];
            end
        end
        // a single key blends with itself; the key 1 word read for it is not used
        if (cmd.cap_hi)
        begin
            t1_reg <= rd_time;
            for (int a = 0; a < kli_pkg::AXES; a++)
            begin
                end_reg[a] <= single ? start_reg[a] : rd_val[a];
            end
        end
        if (cmd.classify)
        begin
            rem_reg    <= t_reg - t0_reg;
            den_reg    <= t1_reg - t0_reg;
            factor_reg <= '0;
            flag_reg   <= 1'b0;
            if (!need_div && !single)
            begin
                flag_reg <= 1'b1;
                if (!found_reg)
                begin
                    factor_reg <= FACTOR_ONE;
                end
            end
        end
        // one quotient bit per step; the remainder stays below the divisor
        if (cmd.div_step)
        begin
            rem_reg    <= div_ge ? TW'(rem_dbl - {1'b0, den_reg}) : rem_dbl[TW-1:0];
            factor_reg <= {factor_reg[FW-2:0], div_ge};
        end
        if (cmd.mul)
        begin
            prod_reg <= delta_sel * $signed({1'b0, factor_reg});
        end
        if (cmd.acc)
        begin
            res_reg[cmd.axis] <= start_sel + shifted[VW-1:0];
        end
        if (cmd.publish)
        begin
            res_data_reg.out_x        <= res_reg[0];
            res_data_reg.out_y        <= res_reg[1];
            res_data_reg.out_z        <= res_reg[2];
            res_data_reg.segment      <= kli_pkg::SLOT_W'(seg_reg);
            res_data_reg.out_of_range <= flag_reg;
        end
    end

    assign status.eval_req = req_valid && (req_data.kind == kli_pkg::KIND_EVAL);
    assign status.single   = single;
    assign status.scan_hit = hit;
    assign status.scan_end = scan_last;
    assign status.need_div = need_div;
    assign status.out_free = !res_valid_reg || res_ready;

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

### design/keyframe_linear_interpolator_unit.sv
// Key write: accepted whenever the unit is idle; no result.
// Evaluate: result after a linear search (one table read per cycle), a 16-step
// restoring divider and a shared 3-axis multiplier; saturated times and a single
// key skip the divider.
// A new request is taken the cycle after the result enters the output register.
// Reset clears the sequencer and output valid, sets key_count to 1; keys are kept.
module keyframe_linear_interpolator_unit #(
    parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kli_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  kli_pkg::kli_in_t              req_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output kli_pkg::kli_out_t             res_data
);

    logic [kli_pkg::CNT_W-1:0] key_count_reg;
    kli_pkg::kli_cmd_t         cmd;
    kli_pkg::kli_status_t      status;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == kli_pkg::REG_KEY_COUNT);
    assign prdata = (paddr == kli_pkg::REG_KEY_COUNT) ?
                    {{(32 - kli_pkg::CNT_W){1'b0}}, key_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= kli_pkg::KEY_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            key_count_reg <= pwdata[kli_pkg::CNT_W-1:0];
        end
    end

    assign req_ready = cmd.idle;

    kli_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    kli_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_data  (req_data),
        .key_count (key_count_reg),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

### dv/keyframe_linear_interpolator_unit_tb.sv
// Self-checking testbench for the keyframe linear interpolator: key writes, evaluations, key_count.
`timescale 1ns / 1ps

module keyframe_linear_interpolator_unit_tb;

    localparam int KEYS          = kli_pkg::MAX_KEYS_DEF;
    localparam int SETTLE_CYCLES = KEYS + 40;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 700;
    localparam int CW            = kli_pkg::CNT_W;
    localparam int TW            = kli_pkg::TIME_W;
    localparam int VW            = kli_pkg::VAL_W;
    localparam int SW            = kli_pkg::SLOT_W;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [kli_pkg::PADDR_W-1:0] paddr     = '0;
    logic [31:0]                 pwdata    = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        req_valid = 1'b0;
    logic                        req_ready;
    kli_pkg::kli_in_t            req_data  = '0;
    logic                        res_valid;
    logic                        res_ready = 1'b0;
    kli_pkg::kli_out_t           res_data;

    keyframe_linear_interpolator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always #6 clk = ~clk;

    // track state as the block should hold it
    logic [CW-1:0]        key_count_cfg = kli_pkg::KEY_COUNT_RST;
    logic [TW-1:0]        key_time [KEYS];
    logic signed [VW-1:0] key_x [KEYS];
    logic signed [VW-1:0] key_y [KEYS];
    logic signed [VW-1:0] key_z [KEYS];

    // key times as the stimulus planned them, used to aim query times
    logic [TW-1:0]        plan_time [KEYS];

    kli_pkg::kli_in_t  pending_requests [$];
    kli_pkg::kli_out_t expected_points [$];
    kli_pkg::kli_out_t want_point;
    kli_pkg::kli_out_t check_point;

    bit calm         = 1'b0;
    int gap_left     = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int planned      = 0;
    int n_errors     = 0;
    int n_writes     = 0;
    int n_evals      = 0;
    int n_saturated  = 0;
    int n_settings   = 0;

    function automatic logic signed [VW-1:0] blend(logic signed [VW-1:0] a,
                                                   logic signed [VW-1:0] b,
                                                   longint factor);
        longint delta;
        longint prod;
        delta = longint'(b) - longint'(a);
        prod  = delta * factor + 32768;
        return a + 32'(prod >>> kli_pkg::FRAC_W);
    endfunction

    function automatic kli_pkg::kli_out_t interp_at(logic [TW-1:0] t);
        kli_pkg::kli_out_t pt;
        int       live;
        int       seg;
        int       i;
        bit       hit;
        longint   factor;
        pt   = '0;
        live = (key_count_cfg == 0) ? 1 : (key_count_cfg > KEYS) ? KEYS : int'(key_count_cfg);
        if (live == 1)
        begin
            pt.out_x = key_x[0];
            pt.out_y = key_y[0];
            pt.out_z = key_z[0];
            return pt;
        end
        seg = live - 2;
        hit = 1'b0;
        for (i = 0; i + 1 < live; i++)
        begin
            if (!hit && t < key_time[i + 1])
            begin
                seg = i;
                hit = 1'b1;
            end
        end
        if (!hit)
        begin
            factor          = 65536;
            pt.out_of_range = 1'b1;
        end
        else if (t < key_time[seg])
        begin
            factor          = 0;
            pt.out_of_range = 1'b1;
        end
        else
        begin
            factor = (longint'(t - key_time[seg]) << kli_pkg::FRAC_W)
                     / longint'(key_time[seg + 1] - key_time[seg]);
        end
        pt.out_x   = blend(key_x[seg], key_x[seg + 1], factor);
        pt.out_y   = blend(key_y[seg], key_y[seg + 1], factor);
        pt.out_z   = blend(key_z[seg], key_z[seg + 1], factor);
        pt.segment = 6'(seg);
        return pt;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        n_errors++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            gap_left  = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                if (req_data.kind == kli_pkg::KIND_WRITE)
                begin
                    key_time[req_data.key_slot] = req_data.sample_time;
                    key_x[req_data.key_slot]    = req_data.value_x;
                    key_y[req_data.key_slot]    = req_data.value_y;
                    key_z[req_data.key_slot]    = req_data.value_z;
                    n_writes++;
                end
                else
                begin
                    want_point = interp_at(req_data.sample_time);
                    expected_points = {expected_points, want_point};
                    n_evals++;
                    if (want_point.out_of_range)
                        n_saturated++;
                end
            end
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (!calm && pending_requests.size() != 0 && $urandom_range(0, 9) == 0)
                begin
                    gap_left = $urandom_range(0, 11);
                    req_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req_data  <= pending_requests.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_points.size() == 0)
                    flag_mismatch("result arrived with nothing expected");
                else
                begin
                    check_point = expected_points.pop_front();
                    if (res_data.out_x !== check_point.out_x)
                        flag_mismatch($sformatf("out_x %h, want %h",
                                                res_data.out_x, check_point.out_x));
                    if (res_data.out_y !== check_point.out_y)
                        flag_mismatch($sformatf("out_y %h, want %h",
                                                res_data.out_y, check_point.out_y));
                    if (res_data.out_z !== check_point.out_z)
                        flag_mismatch($sformatf("out_z %h, want %h",
                                                res_data.out_z, check_point.out_z));
                    if (res_data.segment !== check_point.segment)
                        flag_mismatch($sformatf("segment %0d, want %0d",
                                                res_data.segment, check_point.segment));
                    if (res_data.out_of_range !== check_point.out_of_range)
                        flag_mismatch($sformatf("out_of_range %b, want %b",
                                                res_data.out_of_range,
                                                check_point.out_of_range));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: %0d cycles with no request or result moving", quiet_cycles);
                $display("keyframe_linear_interpolator_unit_tb NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_key(logic [SW-1:0] slot, logic [TW-1:0] t,
                             logic [VW-1:0] x, logic [VW-1:0] y, logic [VW-1:0] z);
        kli_pkg::kli_in_t item;
        item.kind        = kli_pkg::KIND_WRITE;
        item.key_slot    = slot;
        item.sample_time = t;
        item.value_x     = x;
        item.value_y     = y;
        item.value_z     = z;
        plan_time[slot]  = t;
        pending_requests = {pending_requests, item};
        planned++;
    endtask

    task automatic queue_query(logic [TW-1:0] t);
        kli_pkg::kli_in_t item;
        item.kind        = kli_pkg::KIND_EVAL;
        item.key_slot    = SW'($urandom);
        item.sample_time = t;
        item.value_x     = $urandom;
        item.value_y     = $urandom;
        item.value_z     = $urandom;
        pending_requests = {pending_requests, item};
        planned++;
    endtask

    // wait until every request is taken and every result is back, then let writes settle
    task automatic drain();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || req_valid || expected_points.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_key_count(logic [CW-1:0] v);
        drain();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= kli_pkg::REG_KEY_COUNT;
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        key_count_cfg = v;
        n_settings++;
        @(negedge clk);
    endtask

    // one track: new key_count, a fresh set of keys, then queries around them with a stray key write now and then
    task automatic build_track(logic [CW-1:0] cfg);
        logic [TW-1:0] times [KEYS];
        logic [TW-1:0] span;
        logic [TW-1:0] q;
        longint        t_acc;
        int            live;
        int            first;
        int            slot;
        int            k;
        int            n_q;
        set_key_count(cfg);
        live  = (cfg == 0) ? 1 : (cfg > KEYS) ? KEYS : int'(cfg);
        t_acc = ($urandom_range(0, 3) == 0) ? longint'($urandom)
                                            : longint'($urandom_range(0, 32'h0010_0000));
        for (k = 0; k < live; k++)
        begin
            times[k] = (t_acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t_acc[31:0];
            case ($urandom_range(0, 15))
                0:       t_acc += 0;
                1:       t_acc += 1;
                2:       t_acc += longint'($urandom);
                default: t_acc += longint'($urandom_range(1, 32'h0004_0000));
            endcase
        end
        // now and then one key out of order
        if (live > 1 && $urandom_range(0, 5) == 0)
            times[$urandom_range(0, live - 1)] = $urandom;
        first = $urandom_range(0, live - 1);
        for (k = 0; k < live; k++)
        begin
            slot = (first + k) % live;
            queue_key(SW'(slot), times[slot], pick_value(), pick_value(), pick_value());
        end
        n_q = $urandom_range(8, 20);
        repeat (n_q)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_key(SW'($urandom_range(0, KEYS - 1)), $urandom,
                          pick_value(), pick_value(), pick_value());
            k = $urandom_range(0, live - 1);
            case ($urandom_range(0, 6))
                0: q = plan_time[k];
                1: q = plan_time[k] - 1;
                2:
                begin
                    if (k + 1 < live)
                    begin
                        span = plan_time[k + 1] - plan_time[k];
                        q    = plan_time[k] + ((span == 0) ? 32'h0 : $urandom % span);
                    end
                    else
                        q = $urandom;
                end
                3:       q = plan_time[0] - $urandom_range(1, 32'h0001_0000);
                4:       q = plan_time[live - 1] + $urandom_range(0, 32'h0001_0000);
                default: q = $urandom;
            endcase
            queue_query(q);
        end
    endtask

    initial
    begin
        int            directed_end;
        int            phase;
        logic [CW-1:0] cfg;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single key after reset, then key_count 0 behaves as one key
        queue_key(0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        queue_query(32'h0);
        queue_query(32'hFFFF_FFFF);
        queue_key(63, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
        set_key_count(0);
        queue_query(32'h1234_5678);

        // two keys at opposite extremes
        set_key_count(2);
        queue_key(0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        queue_key(1, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000);
        queue_query(32'h0);            // before the first key
        queue_query(32'h0001_0000);
        queue_query(32'h0002_0000);
        queue_query(32'h0002_FFFF);
        queue_query(32'h0003_0000);    // exactly at the last key
        queue_query(32'hFFFF_FFFF);
        // start key later than the end key
        queue_key(0, 32'h0005_0000, 32'h0, 32'h1, 32'hFFFF_FFFF);
        queue_query(32'h0002_0000);
        queue_query(32'h0006_0000);
        // two keys at the same time
        queue_key(1, 32'h0005_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        queue_query(32'h0005_0000);

        directed_end = planned;
        phase        = 0;
        while (planned - directed_end < RANDOM_ITEMS)
        begin
            case (phase)
                0:       cfg = 7'd64;
                1:       cfg = 7'd127;
                2:       cfg = 7'd65;
                3:       cfg = 7'd3;
                default:
                begin
                    case ($urandom_range(0, 11))
                        0:       cfg = 7'd1;
                        1:       cfg = 7'd0;
                        2:       cfg = 7'd64;
                        3:       cfg = CW'($urandom_range(65, 127));
                        4:       cfg = CW'($urandom_range(9, 63));
                        default: cfg = CW'($urandom_range(2, 8));
                    endcase
                end
            endcase
            if (planned - directed_end > RANDOM_ITEMS - 120)
                calm = 1'b1;
            build_track(cfg);
            phase++;
        end

        drain();
        $display("run covered %0d key writes and %0d evaluations (%0d saturated)",
                 n_writes, n_evals, n_saturated);
        $display("key_count was set %0d times over %0d tracks", n_settings, phase);
        if (n_errors == 0)
            $display("keyframe_linear_interpolator_unit_tb OK");
        else
            $display("keyframe_linear_interpolator_unit_tb NOT OK");
        $finish;
    end

endmodule
